[rtl/tsg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsg_pkg: shared types and constants of the text screen pixel generator
// Screen geometry, cell sizes, request codes and inter-module structs.
// ----------------------------------------------------------------------------
package tsg_pkg;

	localparam int TEXT_COLUMNS = 64;
	localparam int TEXT_ROWS    = 32;

	localparam int CW_PRI = 6;
	localparam int CH_PRI = 10;
	localparam int CW_ALT = 8;
	localparam int CH_ALT = 16;

	localparam int W_PRI = TEXT_COLUMNS * CW_PRI;
	localparam int H_PRI = TEXT_ROWS * CH_PRI;
	localparam int W_ALT = TEXT_COLUMNS * CW_ALT;
	localparam int H_ALT = TEXT_ROWS * CH_ALT;

	// reciprocal constants for x / 6 and y / 10 on 9-bit values
	localparam int RECIP6     = 171;
	localparam int RECIP6_SH  = 10;
	localparam int RECIP10    = 205;
	localparam int RECIP10_SH = 11;

	localparam int X_W    = 9;
	localparam int COL_W  = $clog2(TEXT_COLUMNS);
	localparam int ROW_W  = $clog2(TEXT_ROWS);
	localparam int PT_W   = 3;
	localparam int LINE_W = 4;
	localparam int CELL_W = 11;
	localparam int MEM_AW = 12;
	localparam int PROD_W = 17;

	localparam logic [1:0] MODE_VRAM = 2'd0;
	localparam logic [1:0] MODE_FONT = 2'd1;
	localparam logic [1:0] MODE_TICK = 2'd2;

	typedef struct packed {
		logic [X_W-1:0]    x;
		logic [X_W-1:0]    y;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic [PT_W-1:0]   pt;
		logic [LINE_W-1:0] line;
		logic              frame_end;
		logic              last_col;
	} scan_pos_t;

	typedef struct packed {
		logic              tick;
		logic [X_W-1:0]    x;
		logic [X_W-1:0]    y;
		logic [PT_W-1:0]   pt;
		logic [LINE_W-1:0] line;
		logic              frame_end;
		logic              last_col;
		logic [MEM_AW-1:0] faddr;
		logic [7:0]        fdata;
	} pipe_s1_t;

	typedef struct packed {
		logic [X_W-1:0]    x;
		logic [X_W-1:0]    y;
		logic [PT_W-1:0]   pt;
		logic [LINE_W-1:0] line;
		logic              frame_end;
		logic              rvv;
	} pipe_s2_t;

endpackage

[rtl/tsg_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsg_scan: raster position counters
// Steps pixel, cell and line counters per tick; rebuilds them after a
// layout change.
// ----------------------------------------------------------------------------
module tsg_scan import tsg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      alt,
	input  logic      resync,
	input  logic      step,
	output scan_pos_t pos
);

	logic [X_W-1:0]    x_q, y_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [PT_W-1:0]   pt_q;
	logic [LINE_W-1:0] line_q;

	logic [X_W-1:0]    w_last, h_last;
	logic [PT_W-1:0]   cw_last;
	logic [LINE_W-1:0] ch_last;
	logic              x_wrap, y_wrap;

	logic [PROD_W-1:0] prod_x, prod_y;
	logic              in_frame;
	logic [COL_W-1:0]  col_rs;
	logic [ROW_W-1:0]  row_rs;
	logic [PT_W-1:0]   pt_rs;
	logic [LINE_W-1:0] line_rs;

	assign w_last  = alt ? X_W'(W_ALT - 1) : X_W'(W_PRI - 1);
	assign h_last  = alt ? X_W'(H_ALT - 1) : X_W'(H_PRI - 1);
	assign cw_last = alt ? PT_W'(CW_ALT - 1) : PT_W'(CW_PRI - 1);
	assign ch_last = alt ? LINE_W'(CH_ALT - 1) : LINE_W'(CH_PRI - 1);
	assign x_wrap  = (x_q == w_last);
	assign y_wrap  = (y_q == h_last);

	// rebuild counters from the position under the current layout
	assign prod_x   = PROD_W'(x_q) * PROD_W'(RECIP6);
	assign prod_y   = PROD_W'(y_q) * PROD_W'(RECIP10);
	assign in_frame = alt ? ((10'(x_q) < 10'(W_ALT)) && (10'(y_q) < 10'(H_ALT)))
	                      : ((10'(x_q) < 10'(W_PRI)) && (10'(y_q) < 10'(H_PRI)));
	assign col_rs   = alt ? COL_W'(x_q >> 3) : COL_W'(prod_x >> RECIP6_SH);
	assign row_rs   = alt ? ROW_W'(y_q >> 4) : ROW_W'(prod_y >> RECIP10_SH);
	assign pt_rs    = alt ? PT_W'(x_q)
	                      : PT_W'(x_q - X_W'(col_rs) * X_W'(CW_PRI));
	assign line_rs  = alt ? LINE_W'(y_q)
	                      : LINE_W'(y_q - X_W'(row_rs) * X_W'(CH_PRI));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q    <= '0;
			y_q    <= '0;
			col_q  <= '0;
			row_q  <= '0;
			pt_q   <= '0;
			line_q <= '0;
		end else if (resync) begin
			if (in_frame) begin
				col_q  <= col_rs;
				row_q  <= row_rs;
				pt_q   <= pt_rs;
				line_q <= line_rs;
			end else begin
				x_q    <= '0;
				y_q    <= '0;
				col_q  <= '0;
				row_q  <= '0;
				pt_q   <= '0;
				line_q <= '0;
			end
		end else if (step) begin
			if (x_wrap) begin
				x_q   <= '0;
				col_q <= '0;
				pt_q  <= '0;
				if (y_wrap) begin
					y_q    <= '0;
					row_q  <= '0;
					line_q <= '0;
				end else begin
					y_q <= y_q + X_W'(1);
					if (line_q == ch_last) begin
						line_q <= '0;
						row_q  <= row_q + ROW_W'(1);
					end else begin
						line_q <= line_q + LINE_W'(1);
					end
				end
			end else begin
				x_q <= x_q + X_W'(1);
				if (pt_q == cw_last) begin
					pt_q  <= '0;
					col_q <= col_q + COL_W'(1);
				end else begin
					pt_q <= pt_q + PT_W'(1);
				end
			end
		end
	end

	assign pos.x         = x_q;
	assign pos.y         = y_q;
	assign pos.col       = col_q;
	assign pos.row       = row_q;
	assign pos.pt        = pt_q;
	assign pos.line      = line_q;
	assign pos.frame_end = x_wrap && y_wrap;
	assign pos.last_col  = (col_q == COL_W'(TEXT_COLUMNS - 1));

endmodule

[rtl/tsg_vram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsg_vram: video RAM
// One write port, two registered read ports: next cell attribute and code.
// ----------------------------------------------------------------------------
module tsg_vram import tsg_pkg::*; (
	input  logic              clk,
	input  logic              we,
	input  logic [MEM_AW-1:0] waddr,
	input  logic [7:0]        wdata,
	input  logic              rd_en,
	input  logic [CELL_W-1:0] cell_addr,
	output logic [7:0]        attr_s1,
	output logic [7:0]        code_s1
);

	logic [7:0]        mem [2**MEM_AW];
	logic [MEM_AW-1:0] attr_addr, code_addr;

	assign attr_addr = MEM_AW'(cell_addr) + MEM_AW'(1);
	assign code_addr = {1'b1, cell_addr};

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (rd_en) begin
			attr_s1 <= mem[attr_addr];
			code_s1 <= mem[code_addr];
		end
	end

endmodule

[rtl/tsg_font.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsg_font: glyph store
// Single port; glyph row reads and font writes share it in request order.
// ----------------------------------------------------------------------------
module tsg_font import tsg_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic              we,
	input  logic [MEM_AW-1:0] addr,
	input  logic [7:0]        wdata,
	output logic [7:0]        rdata_s2
);

	logic [7:0] mem [2**MEM_AW];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we)
				mem[addr] <= wdata;
			else
				rdata_s2 <= mem[addr];
		end
	end

endmodule

[rtl/text_screen_pixel_generator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_screen_pixel_generator: text mode character generator
// Turns a 64x32 character screen in video RAM into a raster of pixels.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (req_valid / req_stall, mode, address, data): mode 0
//    writes a byte into video RAM (attributes low half, codes high half),
//    mode 1 writes a byte into the glyph store, mode 2 is a pixel tick.
//  - Pixel channel (pix_valid / pix_stall): one pixel per tick with its
//    position and a frame_end flag on the last pixel of the frame.
//  - cfg_we / cfg_data set the layout: 0 is 6x10 cells (384x320), 1 is
//    8x16 cells (512x512). Write it only while the block is idle; the
//    cycle after a write, requests stall while the raster counters are
//    rebuilt for the new layout.
//  - Throughput: one request per clock, ticks back to back, while the
//    pixel side does not stall and no layout rebuild is under way.
//  - Path of a tick: video RAM read, glyph store read, output register.
//  - The glyph store has one port, so font writes travel down the pipe and
//    hit it in request order with glyph reads.
//  - Reset clears the pipe, the raster position (0,0) and the layout;
//    memory contents are undefined until written.
//  - A stalled pixel holds in the output register; the pipe behind it
//    fills and stalls the request side only when no stage is free.
// ----------------------------------------------------------------------------
module text_screen_pixel_generator import tsg_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_data,
	input  logic             req_valid,
	output logic             req_stall,
	input  logic [1:0]       mode,
	input  logic [11:0]      address,
	input  logic [7:0]       data,
	output logic             pix_valid,
	input  logic             pix_stall,
	output logic             bright,
	output logic [X_W-1:0]   pixel_x,
	output logic [X_W-1:0]   pixel_y,
	output logic             frame_end
);

	logic alt_q, resync_q;

	// flow control
	logic out_v_q, s1_v_q, s2_v_q;
	logic out_ld, s2_free, s1_go, s1_free;
	logic accept, acc_tick, acc_font, acc_vram;

	scan_pos_t  pos;
	pipe_s1_t   p_s1;
	pipe_s2_t   p_s2;
	logic [CELL_W-1:0] cell_addr;
	logic [7:0]        attr_s1, code_s1, font_s2;
	logic [MEM_AW-1:0] font_addr;
	logic              font_en, font_we;
	logic              bright_d;

	// output register frees when empty or taken this cycle
	assign out_ld   = !out_v_q || !pix_stall;
	assign s2_free  = !s2_v_q || out_ld;
	// font writes leave stage 1 without needing stage 2
	assign s1_go    = s1_v_q && (!p_s1.tick || s2_free);
	assign s1_free  = !s1_v_q || s1_go;
	assign req_stall = resync_q || !s1_free;

	assign accept   = req_valid && !req_stall;
	assign acc_tick = accept && (mode == MODE_TICK);
	assign acc_font = accept && (mode == MODE_FONT);
	assign acc_vram = accept && (mode == MODE_VRAM);

	// layout register; rebuild raster counters the cycle after a write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alt_q    <= 1'b0;
			resync_q <= 1'b0;
		end else begin
			resync_q <= cfg_we;
			if (cfg_we)
				alt_q <= cfg_data;
		end
	end

	tsg_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.alt    (alt_q),
		.resync (resync_q),
		.step   (acc_tick),
		.pos    (pos)
	);

	assign cell_addr = CELL_W'(pos.row * TEXT_COLUMNS) + CELL_W'(pos.col);

	// stage 0 -> 1: video RAM write or attribute/code read
	tsg_vram u_vram (
		.clk       (clk),
		.we        (acc_vram),
		.waddr     (address),
		.wdata     (data),
		.rd_en     (acc_tick),
		.cell_addr (cell_addr),
		.attr_s1   (attr_s1),
		.code_s1   (code_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (acc_tick || acc_font) begin
			s1_v_q <= 1'b1;
		end else if (s1_go) begin
			s1_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_tick || acc_font) begin
			p_s1.tick      <= acc_tick;
			p_s1.x         <= pos.x;
			p_s1.y         <= pos.y;
			p_s1.pt        <= pos.pt;
			p_s1.line      <= pos.line;
			p_s1.frame_end <= pos.frame_end;
			p_s1.last_col  <= pos.last_col;
			p_s1.faddr     <= address;
			p_s1.fdata     <= data;
		end
	end

	// stage 1 -> 2: glyph row read or font write
	assign font_addr = alt_q ? {code_s1, p_s1.line}
	                         : MEM_AW'({code_s1[6:0], p_s1.line[2:0]});
	assign font_en   = s1_go;
	assign font_we   = !p_s1.tick;

	tsg_font u_font (
		.clk      (clk),
		.en       (font_en),
		.we       (font_we),
		.addr     (font_we ? p_s1.faddr : font_addr),
		.wdata    (p_s1.fdata),
		.rdata_s2 (font_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v_q <= 1'b0;
		end else if (s1_go && p_s1.tick) begin
			s2_v_q <= 1'b1;
		end else if (out_ld) begin
			s2_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && p_s1.tick) begin
			p_s2.x         <= p_s1.x;
			p_s2.y         <= p_s1.y;
			p_s2.pt        <= p_s1.pt;
			p_s2.line      <= p_s1.line;
			p_s2.frame_end <= p_s1.frame_end;
			// reverse video from the next cell, never in the last column
			p_s2.rvv       <= !p_s1.last_col && attr_s1[7];
		end
	end

	// stage 2 -> out: pick the glyph bit and apply polarity
	always_comb begin
		if (alt_q)
			bright_d = font_s2[PT_W'(CW_ALT - 1) - p_s2.pt] ^ p_s2.rvv;
		else if (p_s2.line < LINE_W'(8))
			bright_d = !(font_s2[PT_W'(CW_PRI - 1) - p_s2.pt] ^ p_s2.rvv);
		else
			bright_d = p_s2.rvv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_ld) begin
			out_v_q <= s2_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld && s2_v_q) begin
			bright    <= bright_d;
			pixel_x   <= p_s2.x;
			pixel_y   <= p_s2.y;
			frame_end <= p_s2.frame_end;
		end
	end

	assign pix_valid = out_v_q;

endmodule

[rtl/tsg_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsg_checker: port-level checks for the text screen pixel generator
// Watches the request, pixel and layout ports over time.
// ----------------------------------------------------------------------------
module tsg_checker import tsg_pkg::*; (
	input logic           clk,
	input logic           arst_n,
	input logic           cfg_we,
	input logic           req_stall,
	input logic           pix_valid,
	input logic           pix_stall,
	input logic           bright,
	input logic [X_W-1:0] pixel_x,
	input logic [X_W-1:0] pixel_y,
	input logic           frame_end
);

	// hold a stalled pixel
	assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_stall |=> pix_valid && $stable(bright) &&
		$stable(pixel_x) && $stable(pixel_y) && $stable(frame_end))
	else $error("stalled pixel changed");

	// frame end only at the last pixel of one of the two frames
	assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && frame_end |->
		(10'(pixel_x) == 10'(W_PRI - 1) && 10'(pixel_y) == 10'(H_PRI - 1)) ||
		(10'(pixel_x) == 10'(W_ALT - 1) && 10'(pixel_y) == 10'(H_ALT - 1)))
	else $error("frame_end away from the last pixel");

	// requests stall while counters are rebuilt after a layout write
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> req_stall)
	else $error("request taken during layout resync");

	// no pixel right out of reset
	assert property (@(posedge clk)
		$rose(arst_n) |-> !pix_valid)
	else $error("pixel valid out of reset");

endmodule

bind text_screen_pixel_generator tsg_checker u_tsg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_we    (cfg_we),
	.req_stall (req_stall),
	.pix_valid (pix_valid),
	.pix_stall (pix_stall),
	.bright    (bright),
	.pixel_x   (pixel_x),
	.pixel_y   (pixel_y),
	.frame_end (frame_end)
);

[sim/tb_text_screen_pixel_generator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_screen_pixel_generator: self-checking bench for the text screen
// pixel generator
// Drives video RAM writes, glyph writes and pixel ticks through the request
// channel, predicts every pixel from a private image of both memories and of
// the raster position, and checks each pixel field by field as it leaves.
// Both sides pause at random; memory is primed before any tick reads it.
// ----------------------------------------------------------------------------
module tb_text_screen_pixel_generator;
	import tsg_pkg::*;

	// mode code the block ignores
	localparam logic [1:0] MODE_NONE = 2'd3;

	localparam int ITEM_BUDGET    = 1050;
	localparam int BURST_TICKS    = 64;
	localparam int SETTLE_CYCLES  = 4;    // lets trailing glyph writes land before a layout write, plus margin
	localparam int DRAIN_CYCLES   = 8;
	localparam int QUIET_LIMIT    = 2000;
	localparam int PRINT_LIMIT    = 50;

	typedef struct packed {
		logic           bright;
		logic [X_W-1:0] x;
		logic [X_W-1:0] y;
		logic           fend;
	} pixel_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic             cfg_data;
	logic             req_valid;
	logic             req_stall;
	logic [1:0]       mode;
	logic [11:0]      address;
	logic [7:0]       data;
	logic             pix_valid;
	logic             pix_stall;
	logic             bright;
	logic [X_W-1:0]   pixel_x;
	logic [X_W-1:0]   pixel_y;
	logic             frame_end;

	// private image of the block: memories, what has been written, raster, layout
	logic [7:0]       vram_img [4096];
	logic [7:0]       font_img [4096];
	bit               vram_set [4096];
	bit               font_set [4096];
	logic [X_W-1:0]   scan_x = '0;
	logic [X_W-1:0]   scan_y = '0;
	logic             alt_layout = 1'b0;

	pixel_t           pending_pixels [$];
	int               mismatch_count = 0;
	int               quiet_cycles = 0;
	int               items_sent = 0;
	bit               gaps_enabled = 1'b1;

	text_screen_pixel_generator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.mode      (mode),
		.address   (address),
		.data      (data),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.bright    (bright),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.frame_end (frame_end)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Raster geometry and pixel prediction
	// ------------------------------------------------------------------

	function automatic int frame_w();
		return TEXT_COLUMNS * (alt_layout ? CW_ALT : CW_PRI);
	endfunction

	function automatic int frame_h();
		return TEXT_ROWS * (alt_layout ? CH_ALT : CH_PRI);
	endfunction

	// Position the next tick will use: a raster left outside the current
	// frame by a layout change restarts at the top left corner.
	function automatic void tick_origin(output logic [X_W-1:0] x, output logic [X_W-1:0] y);
		if (scan_x >= frame_w() || scan_y >= frame_h()) begin
			x = '0;
			y = '0;
		end else begin
			x = scan_x;
			y = scan_y;
		end
	endfunction

	function automatic void locate(input logic [X_W-1:0] x, input logic [X_W-1:0] y,
			output int col, output int pt, output int line, output int cell_idx);
		int cw, ch, row;
		cw = alt_layout ? CW_ALT : CW_PRI;
		ch = alt_layout ? CH_ALT : CH_PRI;
		col = x / cw;
		pt = x % cw;
		row = y / ch;
		line = y % ch;
		cell_idx = (row * TEXT_COLUMNS + col) & 'h7FF;
	endfunction

	// Glyph row address for a character code, or -1 on the two bottom lines
	// of the primary cell, which never touch the glyph store.
	function automatic int font_index(input logic [7:0] code, input int line);
		if (alt_layout)
			return (code * 16 + line) & 'hFFF;
		if (line < 8)
			return (code & 'h7F) * 8 + line;
		return -1;
	endfunction

	// Work out the pixel of one tick and advance the raster.
	function automatic pixel_t render_pixel();
		logic [X_W-1:0] x, y;
		int             col, pt, line, cell_idx, fa;
		logic           rvv;
		logic [7:0]     code;
		pixel_t         px;
		tick_origin(x, y);
		locate(x, y, col, pt, line, cell_idx);
		// reverse video comes from the attribute of the cell to the right
		rvv = (col != TEXT_COLUMNS - 1) && vram_img[cell_idx + 1][7];
		code = vram_img[cell_idx + 'h800];
		fa = font_index(code, line);
		if (fa < 0)
			px.bright = rvv;
		else if (alt_layout)
			px.bright = font_img[fa][7 - pt] ^ rvv;
		else
			px.bright = ~(font_img[fa][5 - pt] ^ rvv);
		px.x = x;
		px.y = y;
		px.fend = (x == frame_w() - 1) && (y == frame_h() - 1);
		if (x == frame_w() - 1) begin
			scan_x = '0;
			scan_y = (y == frame_h() - 1) ? '0 : y + 1'b1;
		end else begin
			scan_x = x + 1'b1;
			scan_y = y;
		end
		return px;
	endfunction

	// Fold one accepted request into the image.
	function automatic void apply_request(input logic [1:0] m, input int a, input int d);
		case (m)
			MODE_VRAM: begin
				vram_img[a] = d[7:0];
				vram_set[a] = 1'b1;
			end
			MODE_FONT: begin
				font_img[a] = d[7:0];
				font_set[a] = 1'b1;
			end
			MODE_TICK: begin
				pending_pixels.push_back(render_pixel());
			end
			default: begin
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------

	function automatic int pause_len();
		return gaps_enabled ? $urandom_range(0, 19) : 0;
	endfunction

	// Send one request: wait out a random gap, raise valid with the payload,
	// hold it until the block stops stalling, then record it.
	task automatic push_request(input logic [1:0] m, input int a, input int d);
		int gap;
		gap = pause_len();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		mode <= m;
		address <= a[11:0];
		data <= d[7:0];
		do @(posedge clk); while (req_stall);
		apply_request(m, a, d);
		items_sent++;
	endtask

	// Write every entry the next tick will read that holds nothing yet,
	// so no tick ever reads undefined memory.
	task automatic prime_for_tick();
		logic [X_W-1:0] x, y;
		int             col, pt, line, cell_idx, fa;
		tick_origin(x, y);
		locate(x, y, col, pt, line, cell_idx);
		if (col != TEXT_COLUMNS - 1 && !vram_set[cell_idx + 1])
			push_request(MODE_VRAM, cell_idx + 1, $urandom_range(0, 255));
		if (!vram_set[cell_idx + 'h800])
			push_request(MODE_VRAM, cell_idx + 'h800, $urandom_range(0, 255));
		fa = font_index(vram_img[cell_idx + 'h800], line);
		if (fa >= 0 && !font_set[fa])
			push_request(MODE_FONT, fa, $urandom_range(0, 255));
	endtask

	// Address and data of a tick carry nothing; randomize them anyway.
	task automatic send_tick();
		prime_for_tick();
		push_request(MODE_TICK, $urandom_range(0, 4095), $urandom_range(0, 255));
	endtask

	// Change the layout with the block idle: drop valid, let every pixel
	// out, give trailing glyph writes time to land, then write.
	task automatic write_layout(input logic alt);
		req_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= alt;
		@(posedge clk);
		cfg_we <= 1'b0;
		alt_layout = alt;
	endtask

	// ------------------------------------------------------------------
	// Pixel side: random stall per pixel, checker, watchdog
	// ------------------------------------------------------------------

	initial begin
		int n;
		pix_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			n = pause_len();
			if (n > 0) begin
				pix_stall <= 1'b1;
				repeat (n) @(posedge clk);
				pix_stall <= 1'b0;
			end
			do @(posedge clk); while (!(pix_valid && !pix_stall));
		end
	end

	task automatic flag_mismatch(input string what, input int got, input int want);
		if (mismatch_count < PRINT_LIMIT)
			$display("ERROR %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		pixel_t want_px;
		if (arst_n && pix_valid && !pix_stall) begin
			if (pending_pixels.size() == 0) begin
				flag_mismatch("pixel with none pending, x", pixel_x, -1);
			end else begin
				want_px = pending_pixels.pop_front();
				if (bright !== want_px.bright)
					flag_mismatch($sformatf("bright at (%0d,%0d)", want_px.x, want_px.y),
						bright, want_px.bright);
				if (pixel_x !== want_px.x)
					flag_mismatch("pixel_x", pixel_x, want_px.x);
				if (pixel_y !== want_px.y)
					flag_mismatch("pixel_y", pixel_y, want_px.y);
				if (frame_end !== want_px.fend)
					flag_mismatch($sformatf("frame_end at (%0d,%0d)", want_px.x, want_px.y),
						frame_end, want_px.fend);
			end
		end
	end

	// Any cycle that moves a request or a pixel resets the count.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (pix_valid && !pix_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Primary layout from reset: all-ones and all-zero addresses and data,
	// a code with its top bit set (primary drops it), reverse video on cell 0.
	task automatic test_write_and_tick_extremes();
		push_request(MODE_VRAM, 'h800, 'hFF);
		push_request(MODE_VRAM, 'h001, 'h80);
		push_request(MODE_VRAM, 'h000, 'h00);
		push_request(MODE_VRAM, 'hFFF, 'hFF);
		push_request(MODE_FONT, 'h3F8, 'hA5);
		push_request(MODE_FONT, 'hFFF, 'hFF);
		push_request(MODE_FONT, 'h000, 'h00);
		repeat (8) send_tick();
	endtask

	// Unused mode: no pixel, raster must not move.
	task automatic test_ignored_mode();
		push_request(MODE_NONE, 'hFFF, 'hFF);
		push_request(MODE_NONE, 'h000, 'h00);
		repeat (2) send_tick();
	endtask

	// Alt layout: full 8-bit code, opposite polarity, reverse on cell 1.
	task automatic test_alt_layout();
		write_layout(1'b1);
		push_request(MODE_VRAM, 'h801, 'hFF);
		push_request(MODE_VRAM, 'h002, 'h80);
		push_request(MODE_FONT, 'hFF0, 'h3C);
		repeat (6) send_tick();
	endtask

	// Mixed traffic in phases of random layout and pacing until the request
	// budget is used up; some phases run flat out with no gaps on either side.
	task automatic test_random_traffic();
		int span, pick;
		while (items_sent < ITEM_BUDGET) begin
			write_layout(1'($urandom_range(0, 1)));
			gaps_enabled = ($urandom_range(0, 3) != 0);
			span = $urandom_range(60, 250);
			repeat (span) begin
				if (items_sent >= ITEM_BUDGET)
					break;
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					send_tick();
				end else if (pick < 82) begin
					push_request(MODE_VRAM, $urandom_range(0, 4095), $urandom_range(0, 255));
				end else if (pick < 92) begin
					push_request(MODE_FONT, $urandom_range(0, 4095), $urandom_range(0, 255));
				end else begin
					push_request(MODE_NONE, $urandom_range(0, 4095), $urandom_range(0, 255));
				end
			end
		end
		gaps_enabled = 1'b1;
	endtask

	// Run the alt raster past the primary frame width, then switch back:
	// the next tick has to restart at the top left corner.
	task automatic test_layout_restart();
		logic [X_W-1:0] x, y;
		write_layout(1'b1);
		forever begin
			tick_origin(x, y);
			if (x >= W_PRI)
				break;
			send_tick();
		end
		write_layout(1'b0);
		repeat (6) send_tick();
	endtask

	// Run a burst of primary ticks at full rate with no gaps on either side.
	task automatic test_full_rate_burst();
		write_layout(1'b0);
		gaps_enabled = 1'b0;
		repeat (BURST_TICKS) send_tick();
		gaps_enabled = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_data <= 1'b0;
		req_valid <= 1'b0;
		mode <= MODE_VRAM;
		address <= '0;
		data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_write_and_tick_extremes();
		test_ignored_mode();
		test_alt_layout();
		test_layout_restart();
		test_full_rate_burst();
		test_random_traffic();

		// drain: every pixel out, then watch for strays
		req_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
